/* design/bilinear_rgb_resizer_assert.svh */
// Assertion helpers for the resizer checker.
// The including scope must provide clk and arst_n.
`ifndef BILINEAR_RGB_RESIZER_ASSERT_SVH
`define BILINEAR_RGB_RESIZER_ASSERT_SVH

// Same-cycle implication.
`define BRR_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("brr: same-cycle check failed");

// Next-cycle implication.
`define BRR_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("brr: next-cycle check failed");

`endif

/* design/brr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package brr_pkg;

	localparam int MAX_SRC_COLS = 128;
	localparam int MAX_SRC_ROWS = 128;
	localparam int MAX_DST_COLS = 1024;
	localparam int MAX_DST_ROWS = 1024;

	localparam int STORE_DEPTH = MAX_SRC_COLS * MAX_SRC_ROWS;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int COL_W = $clog2(MAX_SRC_COLS);
	localparam int ROW_W = $clog2(MAX_SRC_ROWS);
	localparam int SW_W = $clog2(MAX_SRC_COLS + 1);
	localparam int SH_W = $clog2(MAX_SRC_ROWS + 1);
	localparam int DCOL_W = $clog2(MAX_DST_COLS);
	localparam int DROW_W = $clog2(MAX_DST_ROWS);

	// Register and field widths fixed by the interface
	localparam int SRC_DIM_W = 8;
	localparam int DST_DIM_W = 11;
	localparam int STEP_W = 24;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;
	localparam int CH_W = 8;
	localparam int NUM_CH = 3;

	localparam int FRAC_W = 16;
	localparam int WGT_W = FRAC_W + 1;
	localparam int ACC_W = WGT_W + CH_W + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SRC_WIDTH,
		REG_SRC_HEIGHT,
		REG_DST_WIDTH,
		REG_DST_HEIGHT,
		REG_COL_STEP,
		REG_ROW_STEP
	} cfg_reg_t;

	// Channel 0 in the low byte
	typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] addr;
		pixel_t            wdata;
	} store_req_t;

	function automatic int clamp_dim(input int v, input int maxv);
		int r;
		r = v;
		if (v < 1) begin
			r = 1;
		end else if (v > maxv) begin
			r = maxv;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* design/brr_store.sv */
`timescale 1ns / 1ps
`default_nettype none

module brr_store (
	input  logic               clk,
	input  brr_pkg::store_req_t req,
	output brr_pkg::pixel_t     rdata
);
	import brr_pkg::*;

	pixel_t mem [STORE_DEPTH];

	// Single port: a write takes the cycle, otherwise a read with registered output
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end else begin
			rdata <= mem[req.addr];
		end
	end

endmodule

`default_nettype wire

/* design/bilinear_rgb_resizer.sv */
`timescale 1ns / 1ps
`default_nettype none

// Bilinear resizer for 3-channel 8-bit pixels.
// Command channel: an item is taken on a clock edge with start high and busy low.
// kind = 0 loads in_ch0..in_ch2 as the next source pixel in raster order; the
// load completes at that edge and busy stays low, so loads run one per cycle.
// kind = 1 emits the next destination pixel. The block raises busy while it
// resolves neighbour indices and weights, makes four frame store reads (one per
// neighbour, single-port store) and closes the weighted sum. The result shows
// on out_ch0..out_ch2 and frame_end with out_valid high for one cycle, as busy
// falls; a new item may be taken in that same cycle. While an emit runs no new
// item is taken; the emit pace is set mostly by the four reads of the single-port
// frame store.
// The receiver cannot stall: out_valid marks each result only in its strobe cycle.
// Configuration: write cfg_data to register cfg_index while cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write only while idle.
// Reset: sizes 128x128 to 128x128, unit steps, load and output counters zero.
// The frame store is not cleared; load the whole frame before emitting.

module bilinear_rgb_resizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic                            kind,
	input  logic [brr_pkg::CH_W-1:0]        in_ch0,
	input  logic [brr_pkg::CH_W-1:0]        in_ch1,
	input  logic [brr_pkg::CH_W-1:0]        in_ch2,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [brr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [brr_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                            out_valid,
	output logic [brr_pkg::CH_W-1:0]        out_ch0,
	output logic [brr_pkg::CH_W-1:0]        out_ch1,
	output logic [brr_pkg::CH_W-1:0]        out_ch2,
	output logic                            frame_end
);
	import brr_pkg::*;

	localparam int POSX_W = DCOL_W + STEP_W;
	localparam int POSY_W = DROW_W + STEP_W;
	localparam logic [WGT_W-1:0] ONE_Q = WGT_W'(1) << FRAC_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_AXIS,
		S_RD,
		S_FIN
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [SRC_DIM_W-1:0] src_width_q, src_height_q;
	logic [DST_DIM_W-1:0] dst_width_q, dst_height_q;
	logic [STEP_W-1:0]    col_step_q, row_step_q;

	// Counters
	logic [ADDR_W-1:0] load_addr_q;
	logic [DCOL_W-1:0] out_col_q;
	logic [DROW_W-1:0] out_row_q;
	logic [1:0]        k_q;

	// Emit datapath
	logic [POSX_W-1:0] pos_x_q;
	logic [POSY_W-1:0] pos_y_q;
	logic [COL_W-1:0]  c0_q, c1_q;
	logic [ADDR_W-1:0] rb0_q, rb1_q;
	logic [WGT_W-1:0]  wx0_q, wx1_q, wy0_q, wy1_q;
	logic [WGT_W-1:0]  w_q;
	logic [ACC_W-1:0]  acc_q [NUM_CH];

	logic [CH_W-1:0] out_ch_q [NUM_CH];
	logic            out_valid_q, frame_end_q;

	logic accept;
	logic [SW_W-1:0] sw;
	logic [SH_W-1:0] sh;
	logic [DCOL_W:0] dw;
	logic [DROW_W:0] dh;
	logic [ADDR_W:0] area;
	logic [ADDR_W-1:0] load_addr_nxt;

	logic [POSX_W-FRAC_W-1:0] ipx;
	logic [POSY_W-FRAC_W-1:0] ipy;
	logic [COL_W-1:0] c0, c1;
	logic [ROW_W-1:0] r0, r1;
	logic [WGT_W-1:0] fx, fy;

	logic [ADDR_W-1:0]   rd_addr;
	logic [WGT_W-1:0]    wa, wb;
	logic [2*WGT_W-1:0]  wprod;
	logic [ACC_W-1:0]    acc_sum [NUM_CH];
	logic [ACC_W-FRAC_W-1:0] res [NUM_CH];
	logic [CH_W-1:0]     sat [NUM_CH];

	logic col_wrap, row_wrap;

	store_req_t req;
	pixel_t     rdata;

	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;

	assign sw = SW_W'(clamp_dim(int'(src_width_q), MAX_SRC_COLS));
	assign sh = SH_W'(clamp_dim(int'(src_height_q), MAX_SRC_ROWS));
	assign dw = (DCOL_W + 1)'(clamp_dim(int'(dst_width_q), MAX_DST_COLS));
	assign dh = (DROW_W + 1)'(clamp_dim(int'(dst_height_q), MAX_DST_ROWS));
	assign area = (ADDR_W + 1)'(sw) * (ADDR_W + 1)'(sh);

	always_comb begin
		if (({1'b0, load_addr_q} + 1'b1) >= area) begin
			load_addr_nxt = '0;
		end else begin
			load_addr_nxt = load_addr_q + 1'b1;
		end
	end

	// Neighbour indices and weights from the registered positions
	always_comb begin
		ipx = pos_x_q[POSX_W-1:FRAC_W];
		ipy = pos_y_q[POSY_W-1:FRAC_W];
		fx  = {1'b0, pos_x_q[FRAC_W-1:0]};
		fy  = {1'b0, pos_y_q[FRAC_W-1:0]};
		if (ipx >= (POSX_W - FRAC_W)'(sw)) begin
			c0 = COL_W'(sw - 1'b1);
		end else begin
			c0 = COL_W'(ipx);
		end
		if ((SW_W'(c0) + SW_W'(1)) >= sw) begin
			c1 = c0;
		end else begin
			c1 = c0 + 1'b1;
		end
		if (ipy >= (POSY_W - FRAC_W)'(sh)) begin
			r0 = ROW_W'(sh - 1'b1);
		end else begin
			r0 = ROW_W'(ipy);
		end
		if ((SH_W'(r0) + SH_W'(1)) >= sh) begin
			r1 = r0;
		end else begin
			r1 = r0 + 1'b1;
		end
	end

	// Read order: top-left, top-right, bottom-left, bottom-right
	always_comb begin
		case (k_q)
			2'd0:    rd_addr = rb0_q + ADDR_W'(c0_q);
			2'd1:    rd_addr = rb0_q + ADDR_W'(c1_q);
			2'd2:    rd_addr = rb1_q + ADDR_W'(c0_q);
			default: rd_addr = rb1_q + ADDR_W'(c1_q);
		endcase
		wa    = k_q[1] ? wy1_q : wy0_q;
		wb    = k_q[0] ? wx1_q : wx0_q;
		wprod = (2 * WGT_W)'(wa) * (2 * WGT_W)'(wb);
	end

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			acc_sum[ch] = acc_q[ch] + ACC_W'(w_q) * ACC_W'(rdata[ch]);
			res[ch]     = acc_sum[ch][ACC_W-1:FRAC_W];
			sat[ch]     = (|res[ch][ACC_W-FRAC_W-1:CH_W]) ? {CH_W{1'b1}} : res[ch][CH_W-1:0];
		end
	end

	assign col_wrap = ({1'b0, out_col_q} + 1'b1) >= dw;
	assign row_wrap = ({1'b0, out_row_q} + 1'b1) >= dh;

	always_comb begin
		req.we    = accept && !kind && (int'(load_addr_q) < STORE_DEPTH);
		req.addr  = (state_q == S_IDLE) ? load_addr_q : rd_addr;
		req.wdata = {in_ch2, in_ch1, in_ch0};
	end

	brr_store u_store (
		.clk   (clk),
		.req   (req),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SRC_DIM_W'(MAX_SRC_COLS);
			src_height_q <= SRC_DIM_W'(MAX_SRC_ROWS);
			dst_width_q  <= DST_DIM_W'(128);
			dst_height_q <= DST_DIM_W'(128);
			col_step_q   <= STEP_W'(ONE_Q);
			row_step_q   <= STEP_W'(ONE_Q);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[SRC_DIM_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[SRC_DIM_W-1:0];
				REG_DST_WIDTH:  dst_width_q  <= cfg_data[DST_DIM_W-1:0];
				REG_DST_HEIGHT: dst_height_q <= cfg_data[DST_DIM_W-1:0];
				REG_COL_STEP:   col_step_q   <= cfg_data[STEP_W-1:0];
				REG_ROW_STEP:   row_step_q   <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			load_addr_q <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_valid_q <= 1'b0;
			frame_end_q <= 1'b0;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				out_ch_q[ch] <= '0;
			end
		end else begin
			out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind) begin
							state_q <= S_AXIS;
						end else begin
							load_addr_q <= load_addr_nxt;
						end
					end
				end
				S_AXIS: begin
					k_q     <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					k_q <= k_q + 1'b1;
					if (&k_q) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					out_valid_q <= 1'b1;
					frame_end_q <= col_wrap && row_wrap;
					for (int ch = 0; ch < NUM_CH; ch++) begin
						out_ch_q[ch] <= sat[ch];
					end
					if (col_wrap) begin
						out_col_q <= '0;
						out_row_q <= row_wrap ? '0 : out_row_q + 1'b1;
					end else begin
						out_col_q <= out_col_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && kind) begin
			pos_x_q <= POSX_W'(out_col_q) * POSX_W'(col_step_q);
			pos_y_q <= POSY_W'(out_row_q) * POSY_W'(row_step_q);
		end
		if (state_q == S_AXIS) begin
			c0_q  <= c0;
			c1_q  <= c1;
			rb0_q <= ADDR_W'(ADDR_W'(r0) * ADDR_W'(sw));
			rb1_q <= ADDR_W'(ADDR_W'(r1) * ADDR_W'(sw));
			wx1_q <= fx;
			wx0_q <= ONE_Q - fx;
			wy1_q <= fy;
			wy0_q <= ONE_Q - fy;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				acc_q[ch] <= '0;
			end
		end
		if (state_q == S_RD) begin
			w_q <= wprod[WGT_W+FRAC_W-1:FRAC_W];
			// data of the previous read arrives now
			if (k_q != '0) begin
				for (int ch = 0; ch < NUM_CH; ch++) begin
					acc_q[ch] <= acc_sum[ch];
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign frame_end = frame_end_q;
	assign out_ch0   = out_ch_q[0];
	assign out_ch1   = out_ch_q[1];
	assign out_ch2   = out_ch_q[2];

endmodule

`default_nettype wire

/* design/brr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module brr_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic kind,
	input logic out_valid
);
	`include "bilinear_rgb_resizer_assert.svh"

	// a result only appears once the emit sequence has released the block
	`BRR_ASSERT_IMPL(a_result_when_free, out_valid, !busy)
	// an accepted emit holds the block
	`BRR_ASSERT_NEXT(a_emit_holds, start && !busy && kind, busy)
	// a load produces no result
	`BRR_ASSERT_NEXT(a_load_silent, start && !busy && !kind, !out_valid)
	// busy rises only on an accepted emit
	`BRR_ASSERT_IMPL(a_busy_cause, $rose(busy), $past(start) && $past(kind))
	`BRR_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid)

endmodule

bind bilinear_rgb_resizer brr_checker u_brr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.kind      (kind),
	.out_valid (out_valid)
);

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
	import brr_pkg::*;

	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EMIT = 1'b1;
	localparam longint unsigned UNITY = 64'h1_0000;
	localparam int DRAIN_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 12;
	localparam int RANDOM_ITEMS = 250;

	typedef struct {
		pixel_t rgb;
		logic   last;
	} resize_out_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic kind;
	logic [CH_W-1:0] in_ch0, in_ch1, in_ch2;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic out_valid;
	logic [CH_W-1:0] out_ch0, out_ch1, out_ch2;
	logic frame_end;

	bilinear_rgb_resizer dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.in_ch0(in_ch0),
		.in_ch1(in_ch1),
		.in_ch2(in_ch2),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ch0(out_ch0),
		.out_ch1(out_ch1),
		.out_ch2(out_ch2),
		.frame_end(frame_end)
	);

	always #2 clk = ~clk;

	// Resizer state as the testbench sees it
	logic [SRC_DIM_W-1:0] src_w_q, src_h_q;
	logic [DST_DIM_W-1:0] dst_w_q, dst_h_q;
	logic [STEP_W-1:0] col_step_q, row_step_q;
	pixel_t frame_mem [STORE_DEPTH];
	int load_ptr, col_ptr, row_ptr;

	resize_out_t pixel_q[$];
	int mismatches = 0;
	int items_sent = 0;
	int burst_left = 0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	function automatic int fit_dim(input int v, input int hi);
		return (v < 1) ? 1 : ((v > hi) ? hi : v);
	endfunction

	function automatic pixel_t rand_pixel(input int extreme_pct);
		pixel_t p;
		int ch;
		for (ch = 0; ch < NUM_CH; ch++) begin
			if ($urandom_range(0, 99) < extreme_pct) begin
				p[ch] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			end else begin
				p[ch] = CH_W'($urandom_range(0, 255));
			end
		end
		return p;
	endfunction

	// Top-left/next neighbour and Q0.16 fraction along one axis
	task automatic locate(input int idx, input logic [STEP_W-1:0] step, input int size,
			output int i0, output int i1, output longint unsigned frac);
		longint unsigned pos;
		longint unsigned whole;
		pos = idx;
		pos = pos * step;
		whole = pos >> FRAC_W;
		frac = pos & 64'hFFFF;
		i0 = (whole >= size) ? size - 1 : int'(whole);
		i1 = (i0 + 1 >= size) ? i0 : i0 + 1;
	endtask

	task automatic interpolate_next(output resize_out_t r);
		int sw, sh, dw, dh, c0, c1, r0, r1, ch, k;
		longint unsigned fx, fy, wx0, wy0, acc;
		longint unsigned wgt [4];
		pixel_t nb [4];
		sw = fit_dim(src_w_q, MAX_SRC_COLS);
		sh = fit_dim(src_h_q, MAX_SRC_ROWS);
		dw = fit_dim(dst_w_q, MAX_DST_COLS);
		dh = fit_dim(dst_h_q, MAX_DST_ROWS);
		locate(col_ptr, col_step_q, sw, c0, c1, fx);
		locate(row_ptr, row_step_q, sh, r0, r1, fy);
		wx0 = UNITY - fx;
		wy0 = UNITY - fy;
		wgt[0] = (wy0 * wx0) >> FRAC_W;
		wgt[1] = (wy0 * fx) >> FRAC_W;
		wgt[2] = (fy * wx0) >> FRAC_W;
		wgt[3] = (fy * fx) >> FRAC_W;
		nb[0] = frame_mem[r0 * sw + c0];
		nb[1] = frame_mem[r0 * sw + c1];
		nb[2] = frame_mem[r1 * sw + c0];
		nb[3] = frame_mem[r1 * sw + c1];
		for (ch = 0; ch < NUM_CH; ch++) begin
			acc = 0;
			for (k = 0; k < 4; k++) begin
				acc = acc + wgt[k] * nb[k][ch];
			end
			acc = acc >> FRAC_W;
			r.rgb[ch] = (acc > 255) ? 8'hFF : acc[CH_W-1:0];
		end
		r.last = 1'b0;
		if (col_ptr + 1 >= dw) begin
			col_ptr = 0;
			if (row_ptr + 1 >= dh) begin
				row_ptr = 0;
				r.last = 1'b1;
			end else begin
				row_ptr++;
			end
		end else begin
			col_ptr++;
		end
	endtask

	task automatic apply_item(input logic is_emit, input pixel_t px);
		resize_out_t r;
		int region;
		if (is_emit) begin
			interpolate_next(r);
			pixel_q.push_back(r);
		end else begin
			region = fit_dim(src_w_q, MAX_SRC_COLS) * fit_dim(src_h_q, MAX_SRC_ROWS);
			if (load_ptr < STORE_DEPTH) begin
				frame_mem[load_ptr] = px;
			end
			load_ptr = (load_ptr + 1 >= region) ? 0 : load_ptr + 1;
		end
	endtask

	// Sender bursts: gaps of random length, now and then a long run with none
	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic send_item(input logic is_emit, input pixel_t px);
		start <= 1'b1;
		kind <= is_emit;
		in_ch0 <= px[0];
		in_ch1 <= px[1];
		in_ch2 <= px[2];
		do @(posedge clk); while (busy);
		apply_item(is_emit, px);
		items_sent++;
		pace();
	endtask

	// Hold off until every pending pixel is out, then let the pipeline settle
	task automatic drain();
		int waited;
		start <= 1'b0;
		waited = 0;
		while (pixel_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pixel_q.size() != 0) begin
			report_mismatch($sformatf("%0d expected pixels never came out", pixel_q.size()));
			pixel_q.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SRC_WIDTH:  src_w_q = data[SRC_DIM_W-1:0];
			REG_SRC_HEIGHT: src_h_q = data[SRC_DIM_W-1:0];
			REG_DST_WIDTH:  dst_w_q = data[DST_DIM_W-1:0];
			REG_DST_HEIGHT: dst_h_q = data[DST_DIM_W-1:0];
			REG_COL_STEP:   col_step_q = data[STEP_W-1:0];
			REG_ROW_STEP:   row_step_q = data[STEP_W-1:0];
			default: ;
		endcase
	endtask

	// Size values sometimes carry junk above the register width
	function automatic logic [CFG_DATA_W-1:0] with_junk(input int value, input int w);
		logic [CFG_DATA_W-1:0] d;
		d = CFG_DATA_W'(value);
		if ($urandom_range(0, 3) == 0) begin
			d = d | CFG_DATA_W'($urandom << w);
		end
		return d;
	endfunction

	task automatic configure(input int sw, input int sh, input int dw, input int dh,
			input logic [STEP_W-1:0] cs, input logic [STEP_W-1:0] rs);
		drain();
		write_reg(REG_SRC_WIDTH, with_junk(sw, SRC_DIM_W));
		write_reg(REG_SRC_HEIGHT, with_junk(sh, SRC_DIM_W));
		write_reg(REG_DST_WIDTH, with_junk(dw, DST_DIM_W));
		write_reg(REG_DST_HEIGHT, with_junk(dh, DST_DIM_W));
		write_reg(REG_COL_STEP, cs);
		write_reg(REG_ROW_STEP, rs);
		cfg_valid <= 1'b0;
	endtask

	// Load one whole source frame; one extra load first if the address sits past it
	task automatic fill_frame(input int extreme_pct);
		int region;
		region = fit_dim(src_w_q, MAX_SRC_COLS) * fit_dim(src_h_q, MAX_SRC_ROWS);
		if (load_ptr >= region) begin
			send_item(KIND_LOAD, rand_pixel(extreme_pct));
		end
		repeat (region) send_item(KIND_LOAD, rand_pixel(extreme_pct));
	endtask

	task automatic emit_run(input int n, input bit reloads);
		repeat (n) begin
			if (reloads && $urandom_range(0, 9) == 0) begin
				send_item(KIND_LOAD, rand_pixel(20));
			end
			send_item(KIND_EMIT, rand_pixel(20));
		end
	endtask

	always @(posedge clk) begin : check_pixels
		resize_out_t want;
		if (arst_n && out_valid) begin
			if (pixel_q.size() == 0) begin
				report_mismatch("pixel came out with none pending");
			end else begin
				want = pixel_q.pop_front();
				if (out_ch0 !== want.rgb[0])
					report_mismatch($sformatf("out_ch0 %0h, want %0h", out_ch0, want.rgb[0]));
				if (out_ch1 !== want.rgb[1])
					report_mismatch($sformatf("out_ch1 %0h, want %0h", out_ch1, want.rgb[1]));
				if (out_ch2 !== want.rgb[2])
					report_mismatch($sformatf("out_ch2 %0h, want %0h", out_ch2, want.rgb[2]));
				if (frame_end !== want.last)
					report_mismatch($sformatf("frame_end %0b, want %0b", frame_end, want.last));
			end
		end
	end

	// Reset geometry is 128x128 at unit steps: load rows 0 and 1 and stay on row 0
	task automatic test_reset_values();
		repeat (2 * MAX_SRC_COLS) send_item(KIND_LOAD, rand_pixel(20));
		emit_run(6, 0);
	endtask

	// 255 wide clamps to 128, 0 high to 1; destination 2047 x 0 becomes 1024 x 1
	task automatic test_size_clamps();
		configure(255, 0, 2047, 0, 24'h0F_8000, 24'hFF_FFFF);
		fill_frame(20);
		emit_run(8, 0);
	endtask

	// Tall narrow source: rows past the last saturate, the column step overshoots
	task automatic test_position_saturation();
		configure(2, 40, 3, 5, 24'hFF_FFFF, 24'h1F_8000);
		fill_frame(20);
		emit_run(17, 0);
	endtask

	task automatic test_weighting();
		configure(2, 2, 3, 3, 24'h00_8000, 24'h00_5556);
		fill_frame(100);
		emit_run(10, 0);
		// zero steps: every pixel is the top-left source pixel
		configure(3, 3, 4, 2, 24'h0, 24'h0);
		fill_frame(50);
		emit_run(9, 0);
	endtask

	task automatic test_spare_indices();
		drain();
		write_reg(IDX_SPARE_LO, 24'hFF_FFFF);
		write_reg(IDX_SPARE_HI, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
		emit_run(5, 1);
	endtask

	// Full 1024-column row, swept across a 32-wide source, through the wrap
	task automatic test_widest_row();
		configure(32, 1, 1024, 1, 24'h00_07C1, 24'h00_4000);
		fill_frame(20);
		emit_run(MAX_DST_COLS - col_ptr + 3, 0);
	endtask

	task automatic pick_step(input int src, input int dst, output logic [STEP_W-1:0] step);
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 6) begin
			step = STEP_W'(((fit_dim(src, MAX_SRC_COLS) << FRAC_W) / fit_dim(dst, MAX_DST_COLS))
				+ $urandom_range(0, 512));
		end else if (mode < 8) begin
			step = STEP_W'($urandom_range(0, 24'h03_0000));
		end else if (mode == 8) begin
			step = STEP_W'($urandom);
		end else begin
			case ($urandom_range(0, 2))
				0: step = 24'h0;
				1: step = 24'hFF_FFFF;
				default: step = 24'h80_0000;
			endcase
		end
	endtask

	task automatic test_random_frames();
		int item_base, sel, sw, sh, dw, dh, n;
		logic [STEP_W-1:0] cs, rs;
		item_base = items_sent;
		while (items_sent - item_base < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 9);
			sw = $urandom_range(1, 12);
			sh = $urandom_range(1, 12);
			dw = $urandom_range(1, 12);
			dh = $urandom_range(1, 12);
			if (sel == 0) begin
				sw = $urandom_range(0, 1) ? 0 : $urandom_range(128, 255);
				sh = $urandom_range(1, 3);
			end else if (sel == 1) begin
				sh = $urandom_range(0, 1) ? 0 : $urandom_range(128, 255);
				sw = $urandom_range(1, 3);
			end else if (sel == 2) begin
				dw = $urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047);
			end else if (sel == 3) begin
				dh = $urandom_range(0, 1) ? 0 : $urandom_range(1025, 2047);
			end
			pick_step(sw, dw, cs);
			pick_step(sh, dh, rs);
			configure(sw, sh, dw, dh, cs, rs);
			fill_frame($urandom_range(0, 40));
			n = fit_dim(dw, MAX_DST_COLS) * fit_dim(dh, MAX_DST_ROWS) + 8;
			emit_run($urandom_range(1, (n > 40) ? 40 : n), 1);
		end
	endtask

	initial begin
		#4_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = KIND_LOAD;
		in_ch0 = '0;
		in_ch1 = '0;
		in_ch2 = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_SRC_WIDTH;
		cfg_data = '0;
		src_w_q = SRC_DIM_W'(MAX_SRC_COLS);
		src_h_q = SRC_DIM_W'(MAX_SRC_ROWS);
		dst_w_q = DST_DIM_W'(128);
		dst_h_q = DST_DIM_W'(128);
		col_step_q = STEP_W'(UNITY);
		row_step_q = STEP_W'(UNITY);
		load_ptr = 0;
		col_ptr = 0;
		row_ptr = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_size_clamps();
		test_position_saturation();
		test_weighting();
		test_spare_indices();
		test_widest_row();
		test_random_frames();

		drain();
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
